// File: rtl/sfir_pkg.sv
`default_nettype none
package sfir_pkg;

  localparam int MAX_TAPS     = 8;
  localparam int MAX_STEP     = 4096;
  localparam int COEFF_SLOTS  = 8;
  localparam int NUM_CELLS    = (MAX_TAPS < COEFF_SLOTS) ? MAX_TAPS : COEFF_SLOTS;
  localparam int STRIDE_LIMIT = 4096;
  localparam int STORE_DEPTH  = (MAX_TAPS - 1) * MAX_STEP + 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam int PIX_W       = 8;
  localparam int COEFF_W     = 16;
  localparam int PROD_W      = PIX_W + 1 + COEFF_W;
  localparam int ACC_W       = PROD_W + $clog2(NUM_CELLS);
  localparam int FRAC_BITS   = 12;

  localparam int TAP_CNT_W   = 4;
  localparam int DIM_W       = 13;
  localparam int STEP_W      = $clog2(MAX_STEP + 1);
  localparam int COEFF_REG_W = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int COUNT_W     = 24;
  localparam int COL_W       = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT,
    REG_SAMPLE_STEP,
    REG_LINE_STRIDE,
    REG_ACTIVE_WIDTH,
    REG_COEFF_01,
    REG_COEFF_23,
    REG_COEFF_45,
    REG_COEFF_67
  } cfg_reg_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic shift;
    logic clear;
    logic reduce;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/strided_fir_u8_filter_core.sv
`default_nettype none
// Strided 8-bit FIR filter, one pass of a separable convolution. Pixels of a
// padded image come in raster order, one item per handshake; each result is
// the sum over taps r of in[p + r*step] times signed Q4.12 coefficient r,
// truncated toward zero and clamped to 0..255, tagged with its position p.
// Step 1 gives a horizontal pass, step equal to the line stride a vertical
// one. Results appear only for columns below active_width and only once the
// full tap window of the frame has arrived; frame_start restarts position and
// column counting. Items are taken one at a time: the delay memory has a single
// read port, so the window is fetched one tap per cycle, and the partial sum
// then walks down the chain of tap cells one cell per cycle.
// A finished result waits in the output register, so the next item can be
// taken while it is stalled. Configuration may only be written between items.
module strided_fir_u8_filter_core
  import sfir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [PIX_W-1:0]      pixel_in,
  input  wire logic                  frame_start,
  // result items
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [PIX_W-1:0]      pixel_out,
  output      logic [COUNT_W-1:0]    out_offset
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAND,
    ST_MUL,
    ST_REDUCE,
    ST_FIN
  } state_t;

  // configuration registers
  logic [TAP_CNT_W-1:0]   tap_count;
  logic [DIM_W-1:0]       sample_step;
  logic [DIM_W-1:0]       line_stride;
  logic [DIM_W-1:0]       active_width;
  logic [COEFF_REG_W-1:0] coeff_regs [COEFF_SLOTS/2];

  // sequencer and stream state
  state_t               state;
  logic [TAP_CNT_W-1:0] cnt;
  logic [TAP_CNT_W-1:0] taps_r;
  logic [STEP_W-1:0]    step_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_vld;
  logic                 emit_r;
  logic [COUNT_W-1:0]   pos_r;
  logic [ADDR_W-1:0]    wi;
  logic [COUNT_W-1:0]   seen;
  logic [COL_W-1:0]     col;

  logic in_accept;
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count    <= TAP_CNT_W'(1);
      sample_step  <= DIM_W'(1);
      line_stride  <= DIM_W'(1);
      active_width <= DIM_W'(1);
      for (int i = 0; i < COEFF_SLOTS/2; i++) begin
        coeff_regs[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_TAP_COUNT:    tap_count     <= cfg_data[TAP_CNT_W-1:0];
        REG_SAMPLE_STEP:  sample_step   <= cfg_data[DIM_W-1:0];
        REG_LINE_STRIDE:  line_stride   <= cfg_data[DIM_W-1:0];
        REG_ACTIVE_WIDTH: active_width  <= cfg_data[DIM_W-1:0];
        REG_COEFF_01:     coeff_regs[0] <= cfg_data[COEFF_REG_W-1:0];
        REG_COEFF_23:     coeff_regs[1] <= cfg_data[COEFF_REG_W-1:0];
        REG_COEFF_45:     coeff_regs[2] <= cfg_data[COEFF_REG_W-1:0];
        REG_COEFF_67:     coeff_regs[3] <= cfg_data[COEFF_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective settings, out-of-range values clamped
  logic [TAP_CNT_W-1:0] taps_eff;
  logic [STEP_W-1:0]    step_eff;
  logic [DIM_W-1:0]     stride_eff;
  logic [TAP_CNT_W+STEP_W-1:0] lag;

  always_comb begin
    if (tap_count == '0) begin
      taps_eff = TAP_CNT_W'(1);
    end else if (32'(tap_count) > NUM_CELLS) begin
      taps_eff = TAP_CNT_W'(NUM_CELLS);
    end else begin
      taps_eff = tap_count;
    end
    if (32'(sample_step) > MAX_STEP) begin
      step_eff = STEP_W'(MAX_STEP);
    end else begin
      step_eff = STEP_W'(sample_step);
    end
    if (line_stride == '0) begin
      stride_eff = DIM_W'(1);
    end else if (32'(line_stride) > STRIDE_LIMIT) begin
      stride_eff = DIM_W'(STRIDE_LIMIT);
    end else begin
      stride_eff = line_stride;
    end
  end

  // samples between a window's first tap and its newest one
  assign lag = (TAP_CNT_W+STEP_W)'(taps_eff - TAP_CNT_W'(1))
             * (TAP_CNT_W+STEP_W)'(step_eff);

  // position and column bookkeeping for the incoming item
  logic [COUNT_W-1:0] seen_eff;
  logic [COL_W-1:0]   col_eff;
  logic [COL_W-1:0]   col_cur;
  logic [DIM_W-1:0]   col_inc;
  logic [COL_W-1:0]   col_adv;
  logic               cnt_full;
  logic               warm;
  logic [COUNT_W-1:0] lag_ext;

  always_comb begin
    lag_ext  = COUNT_W'(lag);
    seen_eff = frame_start ? '0 : seen;
    col_eff  = frame_start ? '0 : col;
    cnt_full = (seen_eff == COUNT_MAX);
    warm     = (seen_eff >= lag_ext);
    // column beyond a lowered stride restarts at zero
    col_cur  = ({1'b0, col_eff} >= stride_eff) ? '0 : col_eff;
    col_inc  = {1'b0, col_cur} + DIM_W'(1);
    col_adv  = (col_inc >= stride_eff) ? '0 : col_inc[COL_W-1:0];
  end

  // next read address walks back one step per tap, wrapping in the store
  logic [ADDR_W:0] rd_back;
  always_comb begin
    if ({1'b0, rd_addr} >= (ADDR_W+1)'(step_r)) begin
      rd_back = {1'b0, rd_addr} - (ADDR_W+1)'(step_r);
    end else begin
      rd_back = {1'b0, rd_addr} + (ADDR_W+1)'(STORE_DEPTH) - (ADDR_W+1)'(step_r);
    end
  end

  // delay store
  logic [PIX_W-1:0] rd_data;

  sfir_store u_store (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr (wi),
    .wr_data (pixel_in),
    .rd_en   (state == ST_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // tap cell chain: samples shift toward higher cells, sums toward cell 0
  cell_ctl_t               cell_ctl;
  logic [PIX_W-1:0]        chain_pix [NUM_CELLS+1];
  logic signed [ACC_W-1:0] chain_acc [NUM_CELLS+1];

  assign cell_ctl.shift  = rd_vld;
  assign cell_ctl.clear  = (state == ST_MUL);
  assign cell_ctl.reduce = (state == ST_REDUCE);

  assign chain_pix[0]         = rd_data;
  assign chain_acc[NUM_CELLS] = '0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sfir_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .active     (taps_r > TAP_CNT_W'(k)),
      .coeff      ($signed(coeff_regs[k/2][(k%2)*COEFF_W +: COEFF_W])),
      .sample_in  (chain_pix[k]),
      .sample_out (chain_pix[k+1]),
      .acc_in     (chain_acc[k+1]),
      .acc_out    (chain_acc[k])
    );
  end

  // truncate toward zero, then clamp to the pixel range
  logic signed [ACC_W-1:0]      sum;
  logic [ACC_W-FRAC_BITS-1:0]   sum_int;
  logic [PIX_W-1:0]             sum_pix;

  always_comb begin
    sum     = chain_acc[0];
    sum_int = sum[ACC_W-1:FRAC_BITS];
    if (sum[ACC_W-1] || (sum == '0)) begin
      sum_pix = '0;
    end else if (|sum_int[ACC_W-FRAC_BITS-1:PIX_W]) begin
      sum_pix = {PIX_W{1'b1}};
    end else begin
      sum_pix = sum_int[PIX_W-1:0];
    end
  end

  logic out_free;
  logic out_load;
  assign out_free = !out_valid || !out_stall;
  // finished result goes to the output register
  assign out_load = (state == ST_FIN) && emit_r && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      emit_r    <= 1'b0;
      wi        <= '0;
      seen      <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= (state == ST_READ);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            wi      <= (wi == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wi + ADDR_W'(1);
            rd_addr <= wi;
            cnt     <= taps_eff;
            taps_r  <= taps_eff;
            step_r  <= step_eff;
            pos_r   <= seen_eff - lag_ext;
            // a full counter freezes counting; warm-up leaves the column alone
            seen    <= cnt_full ? seen_eff : seen_eff + COUNT_W'(1);
            col     <= (!cnt_full && warm) ? col_adv : col_eff;
            emit_r  <= !cnt_full && warm && ({1'b0, col_cur} < active_width);
            state   <= ST_READ;
          end
        end
        ST_READ: begin
          rd_addr <= rd_back[ADDR_W-1:0];
          cnt     <= cnt - TAP_CNT_W'(1);
          if (cnt == TAP_CNT_W'(1)) begin
            state <= ST_LAND;
          end
        end
        ST_LAND: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          cnt   <= taps_r;
          state <= ST_REDUCE;
        end
        ST_REDUCE: begin
          cnt <= cnt - TAP_CNT_W'(1);
          if (cnt == TAP_CNT_W'(1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!emit_r) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pixel_out  <= sum_pix;
            out_offset <= pos_r;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // read addresses stay inside the store
  a_rd_addr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> ({1'b0, rd_addr} < (ADDR_W+1)'(STORE_DEPTH)))
    else $error("read address beyond delay store");

  // all fetched samples have landed in the chain before summing
  a_no_shift_in_reduce: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REDUCE) |-> !rd_vld)
    else $error("sample shift during reduction");

  // frame start restarts the sample count
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && frame_start) |=> (seen == COUNT_W'(1)))
    else $error("frame start did not restart count");

  // an emitted result is loaded when the output register is free
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && emit_r && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("result not delivered to output register");

endmodule
`default_nettype wire

// File: rtl/sfir_store.sv
`default_nettype none
module sfir_store
  import sfir_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [PIX_W-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/sfir_cell.sv
`default_nettype none
module sfir_cell
  import sfir_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic                     active,
  input  wire logic signed [COEFF_W-1:0] coeff,
  input  wire logic [PIX_W-1:0]         sample_in,
  output      logic [PIX_W-1:0]         sample_out,
  input  wire logic signed [ACC_W-1:0]  acc_in,
  output      logic signed [ACC_W-1:0]  acc_out
);

  logic [PIX_W-1:0]         sample;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sample <= sample_in;
    end
    // idle taps contribute nothing
    if (active) begin
      prod <= $signed({1'b0, sample}) * coeff;
    end else begin
      prod <= '0;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.reduce) begin
      acc <= acc_in + ACC_W'(prod);
    end
  end

  assign sample_out = sample;
  assign acc_out    = acc;

endmodule
`default_nettype wire
